// ----- hdl/ffa_pkg.sv -----
// ---------------------------------------------------------------------------
// ffa_pkg
// Shared constants, command codes and sequencer states of the first-fit
// named block allocator.
// ---------------------------------------------------------------------------
package ffa_pkg;

    localparam int MAX_SEGMENTS_DEF = 256;
    localparam int MAX_NAMES_DEF    = 256;
    localparam int ADDR_BITS_DEF    = 20;
    localparam int KEY_BITS         = 32;
    localparam int CMD_BITS         = 2;
    localparam int POOL_RESET       = 100000;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_NRD  = 13'b0000000000010,
        S_NCMP = 13'b0000000000100,
        S_NDEC = 13'b0000000001000,
        S_SRD  = 13'b0000000010000,
        S_SCMP = 13'b0000000100000,
        S_AUPD = 13'b0000001000000,
        S_FDEC = 13'b0000010000000,
        S_SDRD = 13'b0000100000000,
        S_SDWR = 13'b0001000000000,
        S_SURD = 13'b0010000000000,
        S_SUWR = 13'b0100000000000,
        S_DONE = 13'b1000000000000
    } t_state;

endpackage

// ----- hdl/first_fit_named_block_allocator_core.sv -----
// ---------------------------------------------------------------------------
// first_fit_named_block_allocator_core
// First-fit allocator of named blocks over addresses 1..pool_size, with a
// sorted free-segment table that coalesces on free.
//
//   channel  | direction | signals
//   ---------+-----------+-----------------------------------------------
//   command  | in        | i_valid / o_ready, i_cmd, i_key, i_request_size
//   result   | out       | o_valid / i_ready, o_address, o_found, o_overflow
//   config   | in        | i_cfg_valid / o_cfg_ready, i_cfg_data
//
// A command walks the name table entry by entry, reading each valid one to
// compare its key, then walks the free segments in order and moves the
// entries after a segment that is removed or inserted, between its accept,
// decode, update and result steps; these walks over the name and segment
// RAMs set its length. Reset or a config write rebuilds the free list by
// writing its first segment, without any RAM clearing pass. Config is taken
// only while idle and holds off a command in the same cycle. The result sits
// in an output register; a command finishing while it is untaken holds.
// ---------------------------------------------------------------------------
module first_fit_named_block_allocator_core #(
    parameter int MAX_SEGMENTS = ffa_pkg::MAX_SEGMENTS_DEF,
    parameter int MAX_NAMES    = ffa_pkg::MAX_NAMES_DEF,
    parameter int ADDR_BITS    = ffa_pkg::ADDR_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [ffa_pkg::CMD_BITS-1:0] i_cmd,
    input  logic [ffa_pkg::KEY_BITS-1:0] i_key,
    input  logic [ADDR_BITS-1:0]         i_request_size,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [ADDR_BITS-1:0]         o_address,
    output logic                         o_found,
    output logic                         o_overflow,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [ADDR_BITS-1:0]         i_cfg_data
);
    import ffa_pkg::*;

    localparam int NIW = $clog2(MAX_NAMES);
    localparam int NCW = $clog2(MAX_NAMES + 1);
    localparam int SIW = $clog2(MAX_SEGMENTS);
    localparam int SCW = $clog2(MAX_SEGMENTS + 1);
    localparam int SW  = 2 * ADDR_BITS;
    localparam int NW  = KEY_BITS + 2 * ADDR_BITS;

    t_state                r_state, n_state;
    t_cmd                  r_cmd, n_cmd;
    logic [KEY_BITS-1:0]   r_key, n_key;
    logic [ADDR_BITS-1:0]  r_size, n_size;
    logic [ADDR_BITS-1:0]  r_pool;
    logic                  r_init;
    logic [MAX_NAMES-1:0]  r_nvalid, n_nvalid;
    logic [NCW-1:0]        r_nidx, n_nidx;
    logic                  r_hit, n_hit;
    logic [NIW-1:0]        r_slot, n_slot;
    logic                  r_have_empty, n_have_empty;
    logic [NIW-1:0]        r_empty, n_empty;
    logic [ADDR_BITS-1:0]  r_pos, n_pos;
    logic [ADDR_BITS-1:0]  r_len, n_len;
    logic [SCW-1:0]        r_j, n_j;
    logic [SCW-1:0]        r_k, n_k;
    logic                  r_cur_ok, n_cur_ok;
    logic [ADDR_BITS-1:0]  r_cur_st, n_cur_st;
    logic [ADDR_BITS-1:0]  r_cur_len, n_cur_len;
    logic [ADDR_BITS-1:0]  r_prev_st, n_prev_st;
    logic [ADDR_BITS-1:0]  r_prev_len, n_prev_len;
    logic [SCW-1:0]        r_count, n_count;
    logic [ADDR_BITS-1:0]  r_res_addr, n_res_addr;
    logic                  r_res_found, n_res_found;
    logic                  r_res_ovf, n_res_ovf;
    logic                  r_ovalid, n_ovalid;
    logic [ADDR_BITS-1:0]  r_oaddr, n_oaddr;
    logic                  r_ofound, n_ofound;
    logic                  r_oovf, n_oovf;

    logic                  s_we;
    logic [SIW-1:0]        s_waddr, s_raddr;
    logic [SW-1:0]         s_wdata, s_rdata;
    logic                  m_we;
    logic [NIW-1:0]        m_waddr, m_raddr;
    logic [NW-1:0]         m_wdata, m_rdata;

    logic [ADDR_BITS-1:0]  s_rd_st, s_rd_len;
    logic [KEY_BITS-1:0]   m_rd_key;
    logic [ADDR_BITS-1:0]  m_rd_st, m_rd_len;
    logic                  w_left, w_right;
    logic                  in_acc, cfg_acc;

    assign {s_rd_st, s_rd_len}          = s_rdata;
    assign {m_rd_key, m_rd_st, m_rd_len} = m_rdata;

    assign o_ready     = (r_state == S_IDLE) && !r_init && !i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign in_acc      = i_valid && o_ready;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign o_valid     = r_ovalid;
    assign o_address   = r_oaddr;
    assign o_found     = r_ofound;
    assign o_overflow  = r_oovf;

    assign w_left  = (r_j != '0) &&
                     (({1'b0, r_prev_st} + {1'b0, r_prev_len}) == {1'b0, r_pos});
    assign w_right = r_cur_ok &&
                     (({1'b0, r_pos} + {1'b0, r_len}) == {1'b0, r_cur_st});

    ffa_ram #(.WIDTH(SW), .DEPTH(MAX_SEGMENTS)) u_seg_ram (
        .i_clk  (i_clk),
        .i_we   (s_we),
        .i_waddr(s_waddr),
        .i_wdata(s_wdata),
        .i_raddr(s_raddr),
        .o_rdata(s_rdata)
    );

    ffa_ram #(.WIDTH(NW), .DEPTH(MAX_NAMES)) u_name_ram (
        .i_clk  (i_clk),
        .i_we   (m_we),
        .i_waddr(m_waddr),
        .i_wdata(m_wdata),
        .i_raddr(m_raddr),
        .o_rdata(m_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_size       = r_size;
        n_nvalid     = r_nvalid;
        n_nidx       = r_nidx;
        n_hit        = r_hit;
        n_slot       = r_slot;
        n_have_empty = r_have_empty;
        n_empty      = r_empty;
        n_pos        = r_pos;
        n_len        = r_len;
        n_j          = r_j;
        n_k          = r_k;
        n_cur_ok     = r_cur_ok;
        n_cur_st     = r_cur_st;
        n_cur_len    = r_cur_len;
        n_prev_st    = r_prev_st;
        n_prev_len   = r_prev_len;
        n_count      = r_count;
        n_res_addr   = r_res_addr;
        n_res_found  = r_res_found;
        n_res_ovf    = r_res_ovf;
        n_ovalid     = r_ovalid;
        n_oaddr      = r_oaddr;
        n_ofound     = r_ofound;
        n_oovf       = r_oovf;
        s_we         = 1'b0;
        s_waddr      = r_j[SIW-1:0];
        s_wdata      = {r_cur_st, r_cur_len};
        s_raddr      = r_j[SIW-1:0];
        m_we         = 1'b0;
        m_waddr      = r_hit ? r_slot : r_empty;
        m_wdata      = {r_key, r_cur_st, r_size};
        m_raddr      = r_nidx[NIW-1:0];

        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (r_init) begin
                    s_we    = (r_pool != '0);
                    s_waddr = '0;
                    s_wdata = {ADDR_BITS'(1), r_pool};
                    n_count = (r_pool != '0) ? SCW'(1) : '0;
                end else if (in_acc) begin
                    n_cmd        = t_cmd'(i_cmd);
                    n_key        = i_key;
                    n_size       = i_request_size;
                    n_nidx       = '0;
                    n_hit        = 1'b0;
                    n_have_empty = 1'b0;
                    n_res_addr   = '0;
                    n_res_found  = 1'b0;
                    n_res_ovf    = 1'b0;
                    n_state      = (t_cmd'(i_cmd) == CMD_NONE) ? S_DONE : S_NRD;
                end
            end
            S_NRD: begin
                if (r_nidx == NCW'(MAX_NAMES)) begin
                    n_state = S_NDEC;
                end else if (!r_nvalid[r_nidx[NIW-1:0]]) begin
                    if (!r_have_empty) begin
                        n_have_empty = 1'b1;
                        n_empty      = r_nidx[NIW-1:0];
                    end
                    n_nidx = r_nidx + NCW'(1);
                end else begin
                    n_state = S_NCMP;
                end
            end
            S_NCMP: begin
                if (m_rd_key == r_key) begin
                    n_hit   = 1'b1;
                    n_slot  = r_nidx[NIW-1:0];
                    n_pos   = m_rd_st;
                    n_len   = m_rd_len;
                    n_state = S_NDEC;
                end else begin
                    n_nidx  = r_nidx + NCW'(1);
                    n_state = S_NRD;
                end
            end
            S_NDEC: begin
                n_j      = '0;
                n_cur_ok = 1'b0;
                priority if (r_cmd == CMD_QUERY) begin
                    n_res_addr  = r_hit ? r_pos : '0;
                    n_res_found = r_hit;
                    n_state     = S_DONE;
                end else if (r_cmd == CMD_FREE) begin
                    n_state = r_hit ? S_SRD : S_DONE;
                end else if (!r_hit && !r_have_empty) begin
                    n_res_ovf = 1'b1;
                    n_state   = S_DONE;
                end else if (r_size == '0) begin
                    n_nvalid[r_slot] = r_hit ? 1'b0 : r_nvalid[r_slot];
                    n_state          = S_DONE;
                end else begin
                    n_state = S_SRD;
                end
            end
            S_SRD: begin
                if (r_j == r_count) begin
                    if (r_cmd == CMD_FREE) begin
                        n_state = S_FDEC;
                    end else begin
                        if (r_hit) begin
                            n_nvalid[r_slot] = 1'b0;
                        end
                        n_state = S_DONE;
                    end
                end else begin
                    n_state = S_SCMP;
                end
            end
            S_SCMP: begin
                if (r_cmd == CMD_FREE) begin
                    if (s_rd_st > r_pos) begin
                        n_cur_ok  = 1'b1;
                        n_cur_st  = s_rd_st;
                        n_cur_len = s_rd_len;
                        n_state   = S_FDEC;
                    end else begin
                        n_prev_st  = s_rd_st;
                        n_prev_len = s_rd_len;
                        n_j        = r_j + SCW'(1);
                        n_state    = S_SRD;
                    end
                end else if (s_rd_len >= r_size) begin
                    n_cur_st  = s_rd_st;
                    n_cur_len = s_rd_len;
                    n_state   = S_AUPD;
                end else begin
                    n_j     = r_j + SCW'(1);
                    n_state = S_SRD;
                end
            end
            S_AUPD: begin
                m_we                = 1'b1;
                n_nvalid[m_waddr]   = 1'b1;
                n_res_addr          = r_cur_st;
                n_res_found         = 1'b1;
                if (r_cur_len > r_size) begin
                    s_we    = 1'b1;
                    s_wdata = {r_cur_st + r_size, r_cur_len - r_size};
                    n_state = S_DONE;
                end else begin
                    n_k     = r_j;
                    n_state = S_SDRD;
                end
            end
            S_FDEC: begin
                priority if (!w_left && !w_right && r_count == SCW'(MAX_SEGMENTS)) begin
                    n_res_ovf = 1'b1;
                    n_state   = S_DONE;
                end else begin
                    n_nvalid[r_slot] = 1'b0;
                    n_res_found      = 1'b1;
                    priority if (w_left && w_right) begin
                        s_we    = 1'b1;
                        s_waddr = SIW'(r_j - SCW'(1));
                        s_wdata = {r_prev_st, r_prev_len + r_len + r_cur_len};
                        n_k     = r_j;
                        n_state = S_SDRD;
                    end else if (w_left) begin
                        s_we    = 1'b1;
                        s_waddr = SIW'(r_j - SCW'(1));
                        s_wdata = {r_prev_st, r_prev_len + r_len};
                        n_state = S_DONE;
                    end else if (w_right) begin
                        s_we    = 1'b1;
                        s_wdata = {r_pos, r_cur_len + r_len};
                        n_state = S_DONE;
                    end else begin
                        n_k     = r_count;
                        n_state = S_SURD;
                    end
                end
            end
            S_SDRD: begin
                s_raddr = SIW'(r_k + SCW'(1));
                if (r_k + SCW'(1) >= r_count) begin
                    n_count = r_count - SCW'(1);
                    n_state = S_DONE;
                end else begin
                    n_state = S_SDWR;
                end
            end
            S_SDWR: begin
                s_we    = 1'b1;
                s_waddr = r_k[SIW-1:0];
                s_wdata = s_rdata;
                n_k     = r_k + SCW'(1);
                n_state = S_SDRD;
            end
            S_SURD: begin
                s_raddr = SIW'(r_k - SCW'(1));
                if (r_k == r_j) begin
                    s_we    = 1'b1;
                    s_wdata = {r_pos, r_len};
                    n_count = r_count + SCW'(1);
                    n_state = S_DONE;
                end else begin
                    n_state = S_SUWR;
                end
            end
            S_SUWR: begin
                s_we    = 1'b1;
                s_waddr = r_k[SIW-1:0];
                s_wdata = s_rdata;
                n_k     = r_k - SCW'(1);
                n_state = S_SURD;
            end
            S_DONE: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_oaddr  = r_res_addr;
                    n_ofound = r_res_found;
                    n_oovf   = r_res_ovf;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pool   <= ADDR_BITS'(POOL_RESET);
            r_init   <= 1'b1;
            r_nvalid <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_nvalid <= n_nvalid;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
            r_init   <= 1'b0;
            if (cfg_acc) begin
                r_pool   <= i_cfg_data;
                r_init   <= 1'b1;
                r_nvalid <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_key        <= n_key;
        r_size       <= n_size;
        r_nidx       <= n_nidx;
        r_hit        <= n_hit;
        r_slot       <= n_slot;
        r_have_empty <= n_have_empty;
        r_empty      <= n_empty;
        r_pos        <= n_pos;
        r_len        <= n_len;
        r_j          <= n_j;
        r_k          <= n_k;
        r_cur_ok     <= n_cur_ok;
        r_cur_st     <= n_cur_st;
        r_cur_len    <= n_cur_len;
        r_prev_st    <= n_prev_st;
        r_prev_len   <= n_prev_len;
        r_res_addr   <= n_res_addr;
        r_res_found  <= n_res_found;
        r_res_ovf    <= n_res_ovf;
        r_oaddr      <= n_oaddr;
        r_ofound     <= n_ofound;
        r_oovf       <= n_oovf;
    end
endmodule

// ----- hdl/ffa_ram.sv -----
// ---------------------------------------------------------------------------
// ffa_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- sim/tb_first_fit_named_block_allocator_core.sv -----
// ---------------------------------------------------------------------------
// tb_first_fit_named_block_allocator_core
// Drives allocate, free, query and no-op commands into the first-fit allocator,
// predicts each result from a behavioral copy of its free-segment and name
// tables, and checks every result field against that prediction.
// ---------------------------------------------------------------------------
class alloc_scoreboard;

    localparam int NSEG  = 256;
    localparam int NNAME = 256;

    int unsigned pool_size;
    int unsigned seg_start[NSEG];
    int unsigned seg_len[NSEG];
    int unsigned seg_count;
    bit [31:0]   name_key[NNAME];
    int unsigned name_start[NNAME];
    int unsigned name_len[NNAME];
    bit          name_valid[NNAME];
    bit [21:0]   pending[$];
    int          errors;

    function new();
        errors = 0;
        set_pool(ffa_pkg::POOL_RESET);
    endfunction

    function void set_pool(int unsigned size);
        pool_size = size;
        foreach (name_valid[i]) name_valid[i] = 0;
        seg_start[0] = 1;
        seg_len[0]   = size;
        seg_count    = (size != 0) ? 1 : 0;
    endfunction

    function int lookup(bit [31:0] key);
        for (int i = 0; i < NNAME; i++)
            if (name_valid[i] && name_key[i] == key) return i;
        return -1;
    endfunction

    function int free_slot();
        for (int i = 0; i < NNAME; i++)
            if (!name_valid[i]) return i;
        return -1;
    endfunction

    function int names_used();
        int n;
        n = 0;
        foreach (name_valid[i]) n += name_valid[i];
        return n;
    endfunction

    function void drop_seg(int unsigned j);
        for (int unsigned k = j; k + 1 < seg_count; k++) begin
            seg_start[k] = seg_start[k+1];
            seg_len[k]   = seg_len[k+1];
        end
        seg_count--;
    endfunction

    function void note_command(ffa_pkg::t_cmd cmd, bit [31:0] key, bit [19:0] size);
        bit [19:0] addr;
        bit        fnd;
        bit        ovf;
        int        slot;
        int unsigned j;
        int unsigned st;
        int unsigned ln;
        bit        lft;
        bit        rgt;
        addr = 0;
        fnd  = 0;
        ovf  = 0;
        slot = lookup(key);
        case (cmd)
            ffa_pkg::CMD_ALLOC: begin
                if (slot < 0 && free_slot() < 0) begin
                    ovf = 1;
                end else begin
                    for (j = 0; j < seg_count; j++)
                        if (size != 0 && seg_len[j] >= size) break;
                    if (size == 0 || j >= seg_count) begin
                        if (slot >= 0) name_valid[slot] = 0;
                    end else begin
                        st = seg_start[j];
                        if (seg_len[j] > size) begin
                            seg_start[j] = st + size;
                            seg_len[j]   = seg_len[j] - size;
                        end else begin
                            drop_seg(j);
                        end
                        if (slot < 0) slot = free_slot();
                        name_valid[slot] = 1;
                        name_key[slot]   = key;
                        name_start[slot] = st;
                        name_len[slot]   = size;
                        addr = st[19:0];
                        fnd  = 1;
                    end
                end
            end
            ffa_pkg::CMD_FREE: begin
                if (slot >= 0) begin
                    st = name_start[slot];
                    ln = name_len[slot];
                    for (j = 0; j < seg_count; j++)
                        if (seg_start[j] > st) break;
                    lft = j > 0 && longint'(seg_start[j-1]) + seg_len[j-1] == st;
                    rgt = j < seg_count && longint'(st) + ln == seg_start[j];
                    if (!lft && !rgt && seg_count >= NSEG) begin
                        ovf = 1;
                    end else begin
                        if (lft && rgt) begin
                            seg_len[j-1] += ln + seg_len[j];
                            drop_seg(j);
                        end else if (lft) begin
                            seg_len[j-1] += ln;
                        end else if (rgt) begin
                            seg_start[j] = st;
                            seg_len[j]  += ln;
                        end else begin
                            for (int unsigned k = seg_count; k > j; k--) begin
                                seg_start[k] = seg_start[k-1];
                                seg_len[k]   = seg_len[k-1];
                            end
                            seg_start[j] = st;
                            seg_len[j]   = ln;
                            seg_count++;
                        end
                        name_valid[slot] = 0;
                        fnd = 1;
                    end
                end
            end
            ffa_pkg::CMD_QUERY: begin
                if (slot >= 0) begin
                    addr = name_start[slot][19:0];
                    fnd  = 1;
                end
            end
            default: ;
        endcase
        pending.push_back({addr, fnd, ovf});
    endfunction

    function void check_result(bit [19:0] addr, bit fnd, bit ovf);
        bit [21:0] exp_r;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result addr=%0d found=%0b overflow=%0b",
                     $time, addr, fnd, ovf);
            errors++;
            return;
        end
        exp_r = pending.pop_front();
        if (exp_r[21:2] !== addr) begin
            $display("%0t: address expected %0d actual %0d", $time, exp_r[21:2], addr);
            errors++;
        end
        if (exp_r[1] !== fnd) begin
            $display("%0t: found expected %0b actual %0b", $time, exp_r[1], fnd);
            errors++;
        end
        if (exp_r[0] !== ovf) begin
            $display("%0t: overflow expected %0b actual %0b", $time, exp_r[0], ovf);
            errors++;
        end
    endfunction

endclass

module tb_first_fit_named_block_allocator_core;

    timeunit 1ns;
    timeprecision 1ps;

    import ffa_pkg::*;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic [1:0]  i_cmd = '0;
    logic [31:0] i_key = '0;
    logic [19:0] i_request_size = '0;
    logic        o_valid;
    logic        i_ready = 0;
    logic [19:0] o_address;
    logic        o_found;
    logic        o_overflow;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [19:0] i_cfg_data = '0;

    alloc_scoreboard sb = new();
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  recv_hold = 0;
    int  used_keys = 0;
    bit [31:0] key_pool[16];

    first_fit_named_block_allocator_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_cmd(i_cmd), .i_key(i_key), .i_request_size(i_request_size),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_address(o_address), .o_found(o_found), .o_overflow(o_overflow),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result(o_address, o_found, o_overflow);
        if (recv_hold > 0) begin
            recv_hold <= recv_hold - 1;
            i_ready   <= 0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_cmd(t_cmd cmd, bit [31:0] key, bit [19:0] size);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid        <= 1;
        i_cmd          <= cmd;
        i_key          <= key;
        i_request_size <= size;
        do @(posedge i_clk); while (!o_ready);
        sb.note_command(cmd, key, size);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (1100) @(posedge i_clk);
    endtask

    task automatic write_pool(bit [19:0] size);
        drain();
        i_cfg_valid <= 1;
        i_cfg_data  <= size;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        sb.set_pool(size);
        @(posedge i_clk);
    endtask

    function automatic bit [31:0] pick_key();
        return ($urandom_range(7) == 0) ? $urandom() : key_pool[$urandom_range(15)];
    endfunction

    task automatic random_phase(int n, int max_size);
        t_cmd c;
        int   r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            c = (r < 45) ? CMD_ALLOC : (r < 75) ? CMD_FREE : (r < 97) ? CMD_QUERY : CMD_NONE;
            send_cmd(c, pick_key(),
                     (r % 11 == 0) ? 20'($urandom()) : 20'($urandom_range(max_size)));
        end
    endtask

    initial begin
        foreach (key_pool[i]) key_pool[i] = $urandom();
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hFFFF_FFFF;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        send_cmd(CMD_ALLOC, key_pool[0], 20'd10);
        send_cmd(CMD_ALLOC, key_pool[1], 20'd20);
        send_cmd(CMD_ALLOC, key_pool[2], 20'd0);
        send_cmd(CMD_ALLOC, key_pool[3], 20'hFFFFF);
        send_cmd(CMD_QUERY, key_pool[1], 20'd0);
        send_cmd(CMD_QUERY, key_pool[5], 20'd0);
        send_cmd(CMD_FREE,  key_pool[5], 20'd0);
        send_cmd(CMD_ALLOC, key_pool[0], 20'd5);
        send_cmd(CMD_ALLOC, key_pool[1], 20'hFFFFF);
        send_cmd(CMD_QUERY, key_pool[1], 20'd0);
        send_cmd(CMD_FREE,  key_pool[0], 20'd0);
        send_cmd(CMD_NONE,  key_pool[0], 20'hFFFFF);
        send_cmd(CMD_ALLOC, key_pool[4], 20'd99940);

        write_pool(20'd0);
        send_cmd(CMD_ALLOC, key_pool[0], 20'd1);
        write_pool(20'hFFFFF);
        send_cmd(CMD_ALLOC, key_pool[0], 20'hFFFFF);
        send_cmd(CMD_FREE,  key_pool[0], 20'd0);
        send_cmd(CMD_QUERY, key_pool[0], 20'd0);

        // fill the name table, then overflow it
        write_pool(20'd1000);
        for (int i = 0; i < 257; i++) send_cmd(CMD_ALLOC, 32'h1000 + i, 20'd1);
        // free every other block to fragment the free list
        for (int i = 0; i < 257; i += 2) send_cmd(CMD_FREE, 32'h1000 + i, 20'd0);
        write_pool(20'd600);
        for (int i = 0; i < 256; i++) send_cmd(CMD_ALLOC, 32'h2000 + i, 20'd2);
        for (int i = 0; i < 256; i += 2) send_cmd(CMD_FREE, 32'h2000 + i, 20'd0);
        send_cmd(CMD_ALLOC, 32'h3000, 20'd1);
        send_cmd(CMD_FREE,  32'h2001, 20'd0);

        write_pool(20'd64);
        send_idle_pct = 31;
        recv_idle_pct = 57;
        random_phase(60, 12);
        recv_hold <= 300;
        random_phase(40, 12);
        drain();
        send_idle_pct = 57;
        recv_idle_pct = 31;
        write_pool(20'd5000);
        random_phase(60, 300);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_pool(20'd1);
        random_phase(40, 2);
        write_pool(20'd100000);
        random_phase(60, 4000);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #200ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/ffa_pkg.sv
hdl/ffa_ram.sv
hdl/first_fit_named_block_allocator_core.sv
sim/tb_first_fit_named_block_allocator_core.sv
